[hw/rtl/mcs_pkg.sv]
// mcs_pkg: shared types and constants of the mixing cycle sequencer
// no dependencies; imported by mcs_cfg, mcs_core and mixing_cycle_sequencer

package mcs_pkg;

    localparam int unsigned TimeW = 16;
    localparam int unsigned DataW = 32;
    localparam int unsigned AddrW = 4;

    localparam logic [TimeW-1:0] CONFIRM_TIMEOUT_RST = 16'd10000;
    localparam logic [TimeW-1:0] PUMP_ONE_TIME_RST   = 16'd5000;
    localparam logic [TimeW-1:0] MIX_TIME_RST        = 16'd5000;
    localparam logic [TimeW-1:0] DONE_HOLD_RST       = 16'd2000;
    localparam logic [TimeW-1:0] TIME_MAX            = 16'hFFFF;

    localparam logic [1:0] REG_CONFIRM_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_PUMP_ONE_TIME   = 2'd1;
    localparam logic [1:0] REG_MIX_TIME        = 2'd2;
    localparam logic [1:0] REG_DONE_HOLD       = 2'd3;

    localparam int unsigned DRV_PUMP_ONE = 0;
    localparam int unsigned DRV_PUMP_TWO = 1;
    localparam int unsigned DRV_MIXER    = 2;
    localparam int unsigned DRV_VALVE    = 3;

    localparam logic [2:0] STEP_NONE     = 3'd0;
    localparam logic [2:0] STEP_PUMP_ONE = 3'd1;
    localparam logic [2:0] STEP_PUMP_TWO = 3'd2;
    localparam logic [2:0] STEP_MIX      = 3'd3;
    localparam logic [2:0] STEP_DRAIN    = 3'd4;

    typedef enum logic [2:0] {
        MODE_IDLE        = 3'd0,
        MODE_CONFIRM     = 3'd1,
        MODE_MIXING      = 3'd2,
        MODE_INTERRUPTED = 3'd3,
        MODE_EMPTYING    = 3'd4
    } t_mode;

    typedef struct packed {
        logic [TimeW-1:0] confirm_timeout_ms;
        logic [TimeW-1:0] pump_one_time_ms;
        logic [TimeW-1:0] mix_time_ms;
        logic [TimeW-1:0] done_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic start_pressed;
        logic stop_pressed;
        logic level_below_full;
        logic level_above_empty;
    } t_item;

    typedef struct packed {
        logic [3:0] drive;
        t_mode      mode_now;
        logic [2:0] step_now;
    } t_result;

endpackage

[hw/rtl/mcs_cfg.sv]
// mcs_cfg: apb-style configuration registers (timeouts and run times)
// depends on mcs_pkg

module mcs_cfg import mcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.confirm_timeout_ms <= CONFIRM_TIMEOUT_RST;
            r_cfg.pump_one_time_ms   <= PUMP_ONE_TIME_RST;
            r_cfg.mix_time_ms        <= MIX_TIME_RST;
            r_cfg.done_hold_ms       <= DONE_HOLD_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CONFIRM_TIMEOUT: r_cfg.confirm_timeout_ms <= pwdata[TimeW-1:0];
                REG_PUMP_ONE_TIME:   r_cfg.pump_one_time_ms   <= pwdata[TimeW-1:0];
                REG_MIX_TIME:        r_cfg.mix_time_ms        <= pwdata[TimeW-1:0];
                REG_DONE_HOLD:       r_cfg.done_hold_ms       <= pwdata[TimeW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CONFIRM_TIMEOUT: prdata = {{(DataW-TimeW){1'b0}}, r_cfg.confirm_timeout_ms};
            REG_PUMP_ONE_TIME:   prdata = {{(DataW-TimeW){1'b0}}, r_cfg.pump_one_time_ms};
            REG_MIX_TIME:        prdata = {{(DataW-TimeW){1'b0}}, r_cfg.mix_time_ms};
            REG_DONE_HOLD:       prdata = {{(DataW-TimeW){1'b0}}, r_cfg.done_hold_ms};
            default:             prdata = '0;
        endcase
    end

endmodule

[hw/rtl/mcs_core.sv]
// mcs_core: mode/step state registers and the per-tick update logic
// depends on mcs_pkg; config comes from mcs_cfg

module mcs_core import mcs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_mode            r_mode, n_mode;
    logic [2:0]       r_step, n_step;
    logic [TimeW-1:0] r_elapsed, n_elapsed;
    logic [TimeW-1:0] r_hold, n_hold;
    logic [3:0]       r_drive, n_drive;
    logic [TimeW-1:0] elapsed_inc;
    logic             hold_active;

    assign hold_active = (r_hold != '0);
    assign elapsed_inc = (r_elapsed != TIME_MAX) ? r_elapsed + 16'd1 : r_elapsed;

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_step    = r_step;
        n_elapsed = r_elapsed;
        n_hold    = r_hold;
        if (hold_active) begin
            n_hold = r_hold - 16'd1;
        end else begin
            n_elapsed = elapsed_inc;
            case (r_mode)
                MODE_CONFIRM: begin
                    if (i_item.start_pressed) begin
                        n_mode    = MODE_MIXING;
                        n_step    = STEP_PUMP_ONE;
                        n_elapsed = '0;
                    end else if (elapsed_inc > i_cfg.confirm_timeout_ms) begin
                        n_mode = MODE_IDLE;
                    end else if (i_item.stop_pressed) begin
                        n_mode = MODE_INTERRUPTED;
                    end
                end
                MODE_MIXING: begin
                    case (r_step)
                        STEP_PUMP_ONE: begin
                            if (!(elapsed_inc < i_cfg.pump_one_time_ms
                                  && i_item.level_below_full)) begin
                                n_step    = STEP_PUMP_TWO;
                                n_elapsed = '0;
                            end
                        end
                        STEP_PUMP_TWO: begin
                            if (!i_item.level_below_full) begin
                                n_step    = STEP_MIX;
                                n_elapsed = '0;
                            end
                        end
                        STEP_MIX: begin
                            if (!(elapsed_inc < i_cfg.mix_time_ms)) begin
                                n_step = STEP_DRAIN;
                            end
                        end
                        STEP_DRAIN: begin
                            if (!i_item.level_above_empty) begin
                                n_mode = MODE_IDLE;
                                n_hold = i_cfg.done_hold_ms;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (i_item.stop_pressed) begin
                        n_mode = MODE_INTERRUPTED;
                    end
                end
                MODE_INTERRUPTED: begin
                    if (i_item.stop_pressed) begin
                        n_mode = i_item.level_above_empty ? MODE_EMPTYING : MODE_IDLE;
                    end
                end
                MODE_EMPTYING: begin
                    if (!i_item.level_above_empty) begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                    if (i_item.start_pressed) begin
                        n_mode    = MODE_CONFIRM;
                        n_elapsed = '0;
                    end
                end
            endcase
        end
    end

    // drive outputs
    always_comb begin
        n_drive = r_drive;
        if (!hold_active) begin
            case (r_mode)
                MODE_CONFIRM: begin
                end
                MODE_MIXING: begin
                    case (r_step)
                        STEP_PUMP_ONE: n_drive[DRV_PUMP_ONE] =
                            (elapsed_inc < i_cfg.pump_one_time_ms) && i_item.level_below_full;
                        STEP_PUMP_TWO: n_drive[DRV_PUMP_TWO] = i_item.level_below_full;
                        STEP_MIX:      n_drive[DRV_MIXER] = (elapsed_inc < i_cfg.mix_time_ms);
                        STEP_DRAIN:    n_drive[DRV_VALVE] = i_item.level_above_empty;
                        default: begin
                        end
                    endcase
                    if (i_item.stop_pressed) begin
                        n_drive = '0;
                    end
                end
                MODE_INTERRUPTED: begin
                    if (i_item.stop_pressed) begin
                        n_drive[DRV_VALVE] = i_item.level_above_empty;
                    end
                end
                MODE_EMPTYING: n_drive[DRV_VALVE] = i_item.level_above_empty;
                default:       n_drive[DRV_VALVE] = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_step    <= STEP_NONE;
            r_elapsed <= '0;
            r_hold    <= '0;
            r_drive   <= '0;
        end else if (i_en) begin
            r_mode    <= n_mode;
            r_step    <= n_step;
            r_elapsed <= n_elapsed;
            r_hold    <= n_hold;
            r_drive   <= n_drive;
        end
    end

    assign o_result.drive    = n_drive;
    assign o_result.mode_now = n_mode;
    assign o_result.step_now = n_step;

`ifndef SYNTH
    a_hold_drives_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold_active |-> (r_drive == '0))
        else $error("drives on during completion hold");

    a_idle_valve_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> !r_drive[DRV_VALVE])
        else $error("valve open in idle");

    a_hold_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && hold_active) |=> (r_hold == $past(r_hold) - 16'd1))
        else $error("hold counter did not step down");

    a_idle_step_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && hold_active) |=> (r_step == $past(r_step) && r_mode == $past(r_mode)))
        else $error("state moved during completion hold");
`endif

endmodule

[hw/rtl/mixing_cycle_sequencer.sv]
// mixing_cycle_sequencer: top level, input register, core, result register, config port
// depends on mcs_pkg, mcs_cfg, mcs_core
//
//  channel   direction  handshake                   payload
//  in        sink       i_in_valid / o_in_ready     i_start_pressed .. i_level_above_empty
//  out       source     o_out_valid / i_out_ready   o_pump_one_on .. o_step_now
//  cfg       apb slave  psel penable pwrite pready  paddr pwdata prdata
//
// one transaction per cycle sustained while the output is not stalled
// the state update sits between the input register and the result register
// i_rst_n is synchronous; resets state, drives and config to defaults
// a stall on the output backs up into the input register, then o_in_ready drops

module mixing_cycle_sequencer import mcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_start_pressed,
    input  logic             i_stop_pressed,
    input  logic             i_level_below_full,
    input  logic             i_level_above_empty,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_pump_one_on,
    output logic             o_pump_two_on,
    output logic             o_mixer_on,
    output logic             o_valve_open,
    output logic [2:0]       o_mode_now,
    output logic [2:0]       o_step_now,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    logic    advance;
    logic    in_accept;
    t_cfg    cfg;
    t_result core_result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    mcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mcs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.start_pressed     <= i_start_pressed;
            r_item.stop_pressed      <= i_stop_pressed;
            r_item.level_below_full  <= i_level_below_full;
            r_item.level_above_empty <= i_level_above_empty;
        end
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pump_one_on = r_result.drive[DRV_PUMP_ONE];
    assign o_pump_two_on = r_result.drive[DRV_PUMP_TWO];
    assign o_mixer_on    = r_result.drive[DRV_MIXER];
    assign o_valve_open  = r_result.drive[DRV_VALVE];
    assign o_mode_now    = r_result.mode_now;
    assign o_step_now    = r_result.step_now;

endmodule

[tb/sv/mcs_checker.sv]
// mcs_checker: tracks the mixing cycle sequencer channels, predicts every result and compares
// depends on mcs_pkg; follows config writes on the apb port to keep its own register copy

module mcs_checker import mcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_start_pressed,
    input  logic             i_stop_pressed,
    input  logic             i_level_below_full,
    input  logic             i_level_above_empty,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic             i_pump_one_on,
    input  logic             i_pump_two_on,
    input  logic             i_mixer_on,
    input  logic             i_valve_open,
    input  logic [2:0]       i_mode_now,
    input  logic [2:0]       i_step_now,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic             i_pready,
    input  logic [AddrW-1:0] i_paddr,
    input  logic [DataW-1:0] i_pwdata,
    output int               o_pending,
    output int               o_fail_count
);

    t_cfg             cfg_q;
    t_mode            mode_q;
    logic [2:0]       step_q;
    logic [TimeW-1:0] elapsed_q;
    logic [TimeW-1:0] hold_q;
    logic [3:0]       drive_q;
    t_result          expected_drive_q[$];
    t_item            seen;
    t_result          want;
    logic             bad;

    function automatic t_result mix_tick(input t_item it);
        t_result r;
        if (hold_q != '0) begin
            hold_q = hold_q - 1'b1;
        end else begin
            if (elapsed_q != TIME_MAX) elapsed_q = elapsed_q + 1'b1;
            case (mode_q)
                MODE_CONFIRM: begin
                    if (it.start_pressed) begin
                        mode_q    = MODE_MIXING;
                        step_q    = STEP_PUMP_ONE;
                        elapsed_q = '0;
                    end else if (elapsed_q > cfg_q.confirm_timeout_ms) begin
                        mode_q = MODE_IDLE;
                    end else if (it.stop_pressed) begin
                        mode_q = MODE_INTERRUPTED;
                    end
                end
                MODE_MIXING: begin
                    case (step_q)
                        STEP_PUMP_ONE: begin
                            if (elapsed_q < cfg_q.pump_one_time_ms && it.level_below_full) begin
                                drive_q[DRV_PUMP_ONE] = 1'b1;
                            end else begin
                                drive_q[DRV_PUMP_ONE] = 1'b0;
                                step_q    = STEP_PUMP_TWO;
                                elapsed_q = '0;
                            end
                        end
                        STEP_PUMP_TWO: begin
                            if (it.level_below_full) begin
                                drive_q[DRV_PUMP_TWO] = 1'b1;
                            end else begin
                                drive_q[DRV_PUMP_TWO] = 1'b0;
                                step_q    = STEP_MIX;
                                elapsed_q = '0;
                            end
                        end
                        STEP_MIX: begin
                            if (elapsed_q < cfg_q.mix_time_ms) begin
                                drive_q[DRV_MIXER] = 1'b1;
                            end else begin
                                drive_q[DRV_MIXER] = 1'b0;
                                step_q = STEP_DRAIN;
                            end
                        end
                        STEP_DRAIN: begin
                            if (it.level_above_empty) begin
                                drive_q[DRV_VALVE] = 1'b1;
                            end else begin
                                drive_q[DRV_VALVE] = 1'b0;
                                mode_q = MODE_IDLE;
                                hold_q = cfg_q.done_hold_ms;
                            end
                        end
                        default: ;
                    endcase
                    // interrupt wins even in the completing tick
                    if (it.stop_pressed) begin
                        mode_q  = MODE_INTERRUPTED;
                        drive_q = '0;
                    end
                end
                MODE_INTERRUPTED: begin
                    if (it.stop_pressed) begin
                        if (it.level_above_empty) begin
                            mode_q = MODE_EMPTYING;
                            drive_q[DRV_VALVE] = 1'b1;
                        end else begin
                            mode_q = MODE_IDLE;
                            drive_q[DRV_VALVE] = 1'b0;
                        end
                    end
                end
                MODE_EMPTYING: begin
                    if (it.level_above_empty) begin
                        drive_q[DRV_VALVE] = 1'b1;
                    end else begin
                        drive_q[DRV_VALVE] = 1'b0;
                        mode_q = MODE_IDLE;
                    end
                end
                default: begin
                    mode_q = MODE_IDLE;
                    drive_q[DRV_VALVE] = 1'b0;
                    if (it.start_pressed) begin
                        mode_q    = MODE_CONFIRM;
                        elapsed_q = '0;
                    end
                end
            endcase
        end
        r.drive    = drive_q;
        r.mode_now = mode_q;
        r.step_now = step_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q.confirm_timeout_ms = CONFIRM_TIMEOUT_RST;
            cfg_q.pump_one_time_ms   = PUMP_ONE_TIME_RST;
            cfg_q.mix_time_ms        = MIX_TIME_RST;
            cfg_q.done_hold_ms       = DONE_HOLD_RST;
            mode_q       = MODE_IDLE;
            step_q       = STEP_NONE;
            elapsed_q    = '0;
            hold_q       = '0;
            drive_q      = '0;
            expected_drive_q.delete();
            o_pending    = 0;
            o_fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                seen.start_pressed     = i_start_pressed;
                seen.stop_pressed      = i_stop_pressed;
                seen.level_below_full  = i_level_below_full;
                seen.level_above_empty = i_level_above_empty;
                expected_drive_q.push_back(mix_tick(seen));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_drive_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("mismatch: result with nothing expected, mode=%0d step=%0d",
                                 i_mode_now, i_step_now);
                end else begin
                    want = expected_drive_q.pop_front();
                    bad  = (i_pump_one_on !== want.drive[DRV_PUMP_ONE])
                        || (i_pump_two_on !== want.drive[DRV_PUMP_TWO])
                        || (i_mixer_on    !== want.drive[DRV_MIXER])
                        || (i_valve_open  !== want.drive[DRV_VALVE])
                        || (i_mode_now    !== want.mode_now)
                        || (i_step_now    !== want.step_now);
                    if (bad) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("mismatch: expected drive=%b mode=%0d step=%0d",
                                     want.drive, want.mode_now, want.step_now);
                            $display("          got      drive=%b mode=%0d step=%0d",
                                     {i_valve_open, i_mixer_on, i_pump_two_on, i_pump_one_on},
                                     i_mode_now, i_step_now);
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_CONFIRM_TIMEOUT: cfg_q.confirm_timeout_ms = i_pwdata[TimeW-1:0];
                    REG_PUMP_ONE_TIME:   cfg_q.pump_one_time_ms   = i_pwdata[TimeW-1:0];
                    REG_MIX_TIME:        cfg_q.mix_time_ms        = i_pwdata[TimeW-1:0];
                    REG_DONE_HOLD:       cfg_q.done_hold_ms       = i_pwdata[TimeW-1:0];
                    default: ;
                endcase
            end
            o_pending = expected_drive_q.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// tb_top: stimulus and verdict for mixing_cycle_sequencer, directed ticks then random mix cycles
// depends on mcs_pkg, mixing_cycle_sequencer and mcs_checker

module tb_top;
    import mcs_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_start_pressed;
    logic             i_stop_pressed;
    logic             i_level_below_full;
    logic             i_level_above_empty;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_pump_one_on;
    logic             o_pump_two_on;
    logic             o_mixer_on;
    logic             o_valve_open;
    logic [2:0]       o_mode_now;
    logic [2:0]       o_step_now;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    int   pending;
    int   fail_count;
    int   ticks_counted;
    bit   calm;
    t_cfg cfg_now;

    mixing_cycle_sequencer DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_start_pressed     (i_start_pressed),
        .i_stop_pressed      (i_stop_pressed),
        .i_level_below_full  (i_level_below_full),
        .i_level_above_empty (i_level_above_empty),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_pump_one_on       (o_pump_one_on),
        .o_pump_two_on       (o_pump_two_on),
        .o_mixer_on          (o_mixer_on),
        .o_valve_open        (o_valve_open),
        .o_mode_now          (o_mode_now),
        .o_step_now          (o_step_now),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    mcs_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_start_pressed     (i_start_pressed),
        .i_stop_pressed      (i_stop_pressed),
        .i_level_below_full  (i_level_below_full),
        .i_level_above_empty (i_level_above_empty),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_pump_one_on       (o_pump_one_on),
        .i_pump_two_on       (o_pump_two_on),
        .i_mixer_on          (o_mixer_on),
        .i_valve_open        (o_valve_open),
        .i_mode_now          (o_mode_now),
        .i_step_now          (o_step_now),
        .i_psel              (psel),
        .i_penable           (penable),
        .i_pwrite            (pwrite),
        .i_pready            (pready),
        .i_paddr             (paddr),
        .i_pwdata            (pwdata),
        .o_pending           (pending),
        .o_fail_count        (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // random length for a phase whose natural length is limit ticks, capped
    function automatic int span(input int limit);
        return $urandom_range(0, (limit > 20 ? 20 : limit) + 3);
    endfunction

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= calm || !chance(17);
        end
    end

    task automatic send_item(input t_item it);
        while (!calm && chance(17)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_start_pressed     <= it.start_pressed;
        i_stop_pressed      <= it.stop_pressed;
        i_level_below_full  <= it.level_below_full;
        i_level_above_empty <= it.level_above_empty;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // n ticks, each bit high with the given percentage
    task automatic feed(input int n, input int p_start, input int p_stop,
                        input int p_full, input int p_empty, input bit counts);
        t_item it;
        int    k;
        for (k = 0; k < n; k++) begin
            it.start_pressed     = chance(p_start);
            it.stop_pressed      = chance(p_stop);
            it.level_below_full  = chance(p_full);
            it.level_above_empty = chance(p_empty);
            send_item(it);
            if (counts) ticks_counted++;
        end
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TimeW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DataW-TimeW){1'b0}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [TimeW-1:0] ct, input logic [TimeW-1:0] p1,
                              input logic [TimeW-1:0] mx, input logic [TimeW-1:0] hd);
        wait_drained();
        write_reg(REG_CONFIRM_TIMEOUT, ct);
        write_reg(REG_PUMP_ONE_TIME, p1);
        write_reg(REG_MIX_TIME, mx);
        write_reg(REG_DONE_HOLD, hd);
        cfg_now.confirm_timeout_ms = ct;
        cfg_now.pump_one_time_ms   = p1;
        cfg_now.mix_time_ms        = mx;
        cfg_now.done_hold_ms       = hd;
    endtask

    // start, confirm, fill, mix, drain, then the hold; broken runs get frequent interrupts
    task automatic mix_cycle(input bit broken);
        int sp;
        sp = broken ? 12 : 1;
        feed($urandom_range(0, 2), 5, 5, 50, 50, 1);
        feed(1, 100, 20, 50, 50, 1);
        feed(span(int'(cfg_now.confirm_timeout_ms)), 0, 4, 50, 50, 1);
        feed(1, 100, 0, 50, 50, 1);
        feed(span(int'(cfg_now.pump_one_time_ms)), 30, sp, 92, 95, 1);
        feed(span(4), 30, sp, 80, 95, 1);
        feed(span(int'(cfg_now.mix_time_ms)), 30, sp, 8, 95, 1);
        feed(span(4), 30, sp, 8, 75, 1);
        feed(1, 30, broken ? 50 : 0, 8, 0, 1);
        if (broken) feed(span(4), 10, 40, 50, 70, 1);
        feed(int'(cfg_now.done_hold_ms) + int'($urandom_range(0, 2)), 30, 30, 50, 50, 1);
    endtask

    task automatic random_phase(input int n);
        int goal;
        int pick;
        goal = ticks_counted + n;
        while (ticks_counted < goal) begin
            pick = $urandom_range(99);
            if (pick < 60) mix_cycle(1'b0);
            else if (pick < 80) mix_cycle(1'b1);
            else feed($urandom_range(1, 16), 30, 30, 50, 50, 1);
            if (chance(5)) wait_drained();
        end
    endtask

    initial begin
        int ph;
        calm                = 1'b0;
        ticks_counted       = 0;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_start_pressed     = 1'b0;
        i_stop_pressed      = 1'b0;
        i_level_below_full  = 1'b0;
        i_level_above_empty = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_config(16'd3, 16'd2, 16'd2, 16'd2);
        feed(1, 0, 0, 0, 0, 1);
        feed(1, 100, 100, 0, 0, 1);       // start and stop together in idle
        feed(1, 0, 100, 0, 0, 1);         // stop while confirming
        feed(1, 0, 100, 100, 0, 1);       // interrupted with empty tank
        feed(1, 100, 0, 0, 0, 1);
        feed(1, 100, 100, 100, 100, 1);   // confirm beats stop
        feed(3, 0, 0, 100, 100, 1);       // pump one times out, pump two fills
        feed(4, 0, 0, 0, 100, 1);         // full, mix, drain opens
        feed(1, 0, 100, 0, 0, 1);         // stop in the completing tick
        feed(2, 100, 100, 100, 100, 1);   // ignored during hold
        feed(1, 0, 100, 100, 100, 1);     // drain from interrupted
        feed(1, 0, 0, 0, 100, 1);
        feed(1, 0, 0, 0, 0, 1);
        feed(1, 100, 0, 0, 0, 1);
        feed(5, 0, 0, 100, 100, 1);       // confirm timeout

        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        random_phase(250);
        for (ph = 0; ph < 6; ph++) begin
            set_config(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                       16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
            calm = (ph == 2);
            random_phase(250);
        end
        calm = 1'b0;
        set_config(16'd65534, 16'd65534, 16'd65534, 16'd0);
        random_phase(150);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/mcs_pkg.sv
hw/rtl/mcs_cfg.sv
hw/rtl/mcs_core.sv
hw/rtl/mixing_cycle_sequencer.sv
tb/sv/mcs_checker.sv
tb/sv/tb_top.sv
